>>> src/rti_pkg.sv
// Shared types and constants of the ray/triangle intersection block.
// No dependencies; every other file imports this package.
`default_nettype none

package rti_pkg;

  // default coordinate width, Q16.16
  localparam int unsigned COORD_WIDTH_DEF = 32;
  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  // quotient bits produced by the divider
  localparam int unsigned QUO_W = 31;

  typedef enum logic [2:0] {
    RSN_HIT      = 3'd0,
    RSN_SAME     = 3'd1,
    RSN_PARALLEL = 3'd2,
    RSN_U_OUT    = 3'd3,
    RSN_V_OUT    = 3'd4,
    RSN_DIST     = 3'd5
  } reason_e;

  typedef enum logic [2:0] {
    CFG_VERTEX_A_XY  = 3'd0,
    CFG_VERTEX_A_Z   = 3'd1,
    CFG_EDGE_AB_XY   = 3'd2,
    CFG_EDGE_AB_Z    = 3'd3,
    CFG_EDGE_AC_XY   = 3'd4,
    CFG_EDGE_AC_Z    = 3'd5,
    CFG_DET_THRESH   = 3'd6,
    CFG_MIN_DISTANCE = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        best_distance;
    logic               from_this_triangle;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    reason_e     reason;
  } res_t;

  // per-ray side data carried down the front pipeline
  typedef struct packed {
    logic        same;
    logic [30:0] best;
  } meta_t;

  // verdict of the front, travels with the ray to the back
  typedef struct packed {
    reason_e     reason;
    logic        tneg;
    logic [30:0] best;
  } cls_t;

endpackage

`default_nettype wire

>>> src/rti_front.sv
// Front of the intersection block: exact determinant and barycentric numerators,
// then the same-triangle, parallel, u and v checks. Depends on rti_pkg.
`default_nettype none

module rti_front import rti_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  ray_t                            ray_i,
  input  logic signed [COORD_WIDTH-1:0]   a_i  [3],
  input  logic signed [COORD_WIDTH-1:0]   ab_i [3],
  input  logic signed [COORD_WIDTH-1:0]   ac_i [3],
  input  logic [62:0]                     thr_i,
  output logic                            valid_o,
  output cls_t                            cls_o,
  output logic [3*COORD_WIDTH+4:0]        detm_o,
  output logic [3*COORD_WIDTH+4:0]        tnm_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned AW = W + 1;       // multiplicand of the dot products
  localparam int unsigned BW = 2 * W + 2;   // multiplier of the dot products
  localparam int unsigned LW = 2 * W + 2;   // low partial product
  localparam int unsigned HW = 2 * W + 3;   // high partial product
  localparam int unsigned FW = 3 * W + 3;   // full product
  localparam int unsigned NW = 3 * W + 5;   // det, un, vn, tn
  localparam int unsigned MW = (NW > 64) ? NW : 64;

  logic [7:0] vld_q;
  meta_t      meta_q [8];

  logic signed [W-1:0]    o_in [3];
  logic signed [W-1:0]    o1_q [3], d1_q [3];
  logic signed [AW-1:0]   s2_q [3], s3_q [3], s4_q [3];
  logic signed [W-1:0]    d2_q [3], d3_q [3], d4_q [3];
  logic signed [2*W-1:0]  pm_c [6], pm3_q [6];
  logic signed [2*W:0]    qm_c [6], qm3_q [6];
  logic signed [2*W:0]    p_c  [3], p4_q [3];
  logic signed [2*W+1:0]  q_c  [3], q4_q [3];
  logic signed [AW-1:0]   ma [12];
  logic signed [BW-1:0]   mb [12];
  logic signed [W+1:0]    mbh [12];
  logic signed [LW-1:0]   lo_c [12], lo_q [12];
  logic signed [HW-1:0]   hi_c [12], hi_q [12];
  logic signed [FW-1:0]   full_c [12], full_q [12];
  logic signed [NW-1:0]   sum_c [4], sum_q [4];
  logic signed [NW-1:0]   det8_q, un8_q, vn8_q, tn8_q;
  logic signed [NW:0]     uv_sum;
  logic [MW-1:0]          detm_w, thr_w;
  logic                   parallel, u_out, v_out;
  cls_t                   cls_d;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[6:0], start_i};
      valid_o <= vld_q[7];
    end
  end

  // take the low coordinate bits of each slot
  always_comb begin
    o_in[0] = ray_i.origin_x[W-1:0];
    o_in[1] = ray_i.origin_y[W-1:0];
    o_in[2] = ray_i.origin_z[W-1:0];
  end

  // cross-product terms: p = d x ac, q = s x ab
  always_comb begin
    pm_c[0] = d2_q[1] * ac_i[2];
    pm_c[1] = d2_q[2] * ac_i[1];
    pm_c[2] = d2_q[2] * ac_i[0];
    pm_c[3] = d2_q[0] * ac_i[2];
    pm_c[4] = d2_q[0] * ac_i[1];
    pm_c[5] = d2_q[1] * ac_i[0];
    qm_c[0] = s2_q[1] * ab_i[2];
    qm_c[1] = s2_q[2] * ab_i[1];
    qm_c[2] = s2_q[2] * ab_i[0];
    qm_c[3] = s2_q[0] * ab_i[2];
    qm_c[4] = s2_q[0] * ab_i[1];
    qm_c[5] = s2_q[1] * ab_i[0];
    for (int i = 0; i < 3; i++) begin
      p_c[i] = (2*W+1)'(pm3_q[2*i]) - (2*W+1)'(pm3_q[2*i+1]);
      q_c[i] = (2*W+2)'(qm3_q[2*i]) - (2*W+2)'(qm3_q[2*i+1]);
    end
  end

  // dot-product operands: det = ab.p, un = s.p, vn = d.q, tn = ac.q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i]     = AW'(ab_i[i]);
      mb[i]     = BW'(p4_q[i]);
      ma[3 + i] = s4_q[i];
      mb[3 + i] = BW'(p4_q[i]);
      ma[6 + i] = AW'(d4_q[i]);
      mb[6 + i] = q4_q[i];
      ma[9 + i] = AW'(ac_i[i]);
      mb[9 + i] = q4_q[i];
    end
    for (int k = 0; k < 12; k++) begin
      mbh[k]    = mb[k][BW-1:W];
      lo_c[k]   = ma[k] * $signed({1'b0, mb[k][W-1:0]});
      hi_c[k]   = ma[k] * mbh[k];
      full_c[k] = $signed({hi_q[k], {W{1'b0}}}) + FW'(lo_q[k]);
    end
    for (int n = 0; n < 4; n++) begin
      sum_c[n] = NW'(full_q[3*n]) + NW'(full_q[3*n+1]) + NW'(full_q[3*n+2]);
    end
  end

  // classify on the oriented values
  always_comb begin
    detm_w   = MW'($unsigned(det8_q));
    thr_w    = MW'(thr_i);
    uv_sum   = (NW+1)'(un8_q) + (NW+1)'(vn8_q);
    parallel = (det8_q == '0) || (detm_w < thr_w);
    u_out    = (un8_q < 0) || (un8_q > det8_q);
    v_out    = (vn8_q < 0) || (uv_sum > (NW+1)'(det8_q));
    cls_d.best = meta_q[7].best;
    cls_d.tneg = tn8_q < 0;
    if (meta_q[7].same) begin
      cls_d.reason = RSN_SAME;
    end else if (parallel) begin
      cls_d.reason = RSN_PARALLEL;
    end else if (u_out) begin
      cls_d.reason = RSN_U_OUT;
    end else if (v_out) begin
      cls_d.reason = RSN_V_OUT;
    end else begin
      cls_d.reason = RSN_HIT;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    meta_q[0].same <= ray_i.from_this_triangle;
    meta_q[0].best <= ray_i.best_distance;
    for (int m = 1; m < 8; m++) begin
      meta_q[m] <= meta_q[m-1];
    end
    o1_q    <= o_in;
    d1_q[0] <= ray_i.dir_x[W-1:0];
    d1_q[1] <= ray_i.dir_y[W-1:0];
    d1_q[2] <= ray_i.dir_z[W-1:0];
    for (int i = 0; i < 3; i++) begin
      s2_q[i] <= AW'(o1_q[i]) - AW'(a_i[i]);
    end
    d2_q  <= d1_q;
    pm3_q <= pm_c;
    qm3_q <= qm_c;
    s3_q  <= s2_q;
    d3_q  <= d2_q;
    p4_q  <= p_c;
    q4_q  <= q_c;
    s4_q  <= s3_q;
    d4_q  <= d3_q;
    lo_q   <= lo_c;
    hi_q   <= hi_c;
    full_q <= full_c;
    sum_q  <= sum_c;
    // flip orientation on a negative determinant
    if (sum_q[0] < 0) begin
      det8_q <= -sum_q[0];
      un8_q  <= -sum_q[1];
      vn8_q  <= -sum_q[2];
      tn8_q  <= -sum_q[3];
    end else begin
      det8_q <= sum_q[0];
      un8_q  <= sum_q[1];
      vn8_q  <= sum_q[2];
      tn8_q  <= sum_q[3];
    end
    cls_o  <= cls_d;
    detm_o <= $unsigned(det8_q);
    tnm_o  <= (tn8_q < 0) ? $unsigned(-tn8_q) : $unsigned(tn8_q);
  end

endmodule

`default_nettype wire

>>> src/rti_queue.sv
// Short first-in first-out queue between front and back; the back drains it
// whenever it holds a word. Depends on rti_pkg.
`default_nettype none

module rti_queue import rti_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  output logic              full_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              pop;

  assign pop     = count_q != '0;
  assign valid_o = pop;
  assign full_o  = count_q == CW'(DEPTH);
  assign data_o  = mem[rd_ptr_q];

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(pop);
    end
  end

  // store pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/rti_back.sv
// Back of the intersection block: pipelined restoring divide for t, one quotient
// bit per stage, then the distance window check. Depends on rti_pkg.
`default_nettype none

module rti_back import rti_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  cls_t                     cls_i,
  input  logic [3*COORD_WIDTH+4:0] detm_i,
  input  logic [3*COORD_WIDTH+4:0] tnm_i,
  input  logic [30:0]              min_dist_i,
  output logic                     valid_o,
  output res_t                     res_o
);

  localparam int unsigned NW = 3 * COORD_WIDTH + 5;
  localparam int unsigned RW = NW + QUO_W + 1;
  localparam int unsigned NS = QUO_W + 1;

  logic [NS-1:0]    vld_q;
  logic [RW-1:0]    rem_q [NS];
  logic [QUO_W-1:0] quo_q [NS];
  logic [NW-1:0]    dm_q  [NS];
  cls_t             cls_q [NS];
  logic             ovf_q [NS];
  logic [RW-1:0]    num_in, lim_in;
  logic             t_ok;
  res_t             res_d;

  assign num_in = RW'(tnm_i) << 16;
  assign lim_in = RW'(detm_i) << QUO_W;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[NS-2:0], valid_i};
      valid_o <= vld_q[NS-1];
    end
  end

  // load numerator and flag a quotient too large for the field
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_in;
    quo_q[0] <= '0;
    dm_q[0]  <= detm_i;
    cls_q[0] <= cls_i;
    ovf_q[0] <= num_in >= lim_in;
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(dm_q[j]) << (QUO_W - 1 - j);
    assign ge  = rem_q[j] >= dsh;
    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? (rem_q[j] - dsh) : rem_q[j];
      quo_q[j+1] <= {quo_q[j][QUO_W-2:0], ge};
      dm_q[j+1]  <= dm_q[j];
      cls_q[j+1] <= cls_q[j];
      ovf_q[j+1] <= ovf_q[j];
    end
  end

  // a negative nonzero t always falls below the minimum distance
  always_comb begin
    t_ok = !ovf_q[NS-1]
        && !(cls_q[NS-1].tneg && (quo_q[NS-1] != '0))
        && (quo_q[NS-1] >= min_dist_i)
        && (quo_q[NS-1] < cls_q[NS-1].best);
    res_d.hit      = 1'b0;
    res_d.distance = cls_q[NS-1].best;
    res_d.reason   = cls_q[NS-1].reason;
    if (cls_q[NS-1].reason == RSN_HIT) begin
      if (t_ok) begin
        res_d.hit      = 1'b1;
        res_d.distance = quo_q[NS-1];
      end else begin
        res_d.reason = RSN_DIST;
      end
    end
  end

  // hold result for its strobe cycle
  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

`default_nettype wire

>>> src/ray_triangle_intersect.sv
// Ray/triangle intersection, one ray per clock: valid_o rises once the accepted
// ray has passed through the 9-stage front, the queue and the 33-stage divider.
// Throughput is one ray per cycle; busy stays low in normal operation.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue and loads
// the triangle registers with zero, the threshold and minimum distance with one.
`default_nettype none

module ray_triangle_intersect import rti_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ray_t        ray_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        valid_o,
  output res_t        res_o
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned NW      = 3 * W + 5;
  localparam int unsigned QW      = $bits(cls_t) + 2 * NW;
  localparam int unsigned LATENCY = 43;

  logic [63:0] vertex_a_xy_q, edge_ab_xy_q, edge_ac_xy_q;
  logic [31:0] vertex_a_z_q, edge_ab_z_q, edge_ac_z_q;
  logic [62:0] det_thr_q;
  logic [30:0] min_dist_q;

  logic signed [W-1:0] a_v [3], ab_v [3], ac_v [3];
  logic                accept;
  logic                f_valid, q_valid, q_full;
  cls_t                f_cls, q_cls;
  logic [NW-1:0]       f_detm, f_tnm, q_detm, q_tnm;
  logic [QW-1:0]       q_data;

  assign accept = start && !busy;
  assign busy   = q_full;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_a_xy_q <= '0;
      vertex_a_z_q  <= '0;
      edge_ab_xy_q  <= '0;
      edge_ab_z_q   <= '0;
      edge_ac_xy_q  <= '0;
      edge_ac_z_q   <= '0;
      det_thr_q     <= 63'd1;
      min_dist_q    <= 31'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VERTEX_A_XY:  vertex_a_xy_q <= cfg_data_i;
        CFG_VERTEX_A_Z:   vertex_a_z_q  <= cfg_data_i[31:0];
        CFG_EDGE_AB_XY:   edge_ab_xy_q  <= cfg_data_i;
        CFG_EDGE_AB_Z:    edge_ab_z_q   <= cfg_data_i[31:0];
        CFG_EDGE_AC_XY:   edge_ac_xy_q  <= cfg_data_i;
        CFG_EDGE_AC_Z:    edge_ac_z_q   <= cfg_data_i[31:0];
        CFG_DET_THRESH:   det_thr_q     <= cfg_data_i[62:0];
        CFG_MIN_DISTANCE: min_dist_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // pick the low coordinate bits of each slot
  always_comb begin
    a_v[0]  = vertex_a_xy_q[32+W-1:32];
    a_v[1]  = vertex_a_xy_q[W-1:0];
    a_v[2]  = vertex_a_z_q[W-1:0];
    ab_v[0] = edge_ab_xy_q[32+W-1:32];
    ab_v[1] = edge_ab_xy_q[W-1:0];
    ab_v[2] = edge_ab_z_q[W-1:0];
    ac_v[0] = edge_ac_xy_q[32+W-1:32];
    ac_v[1] = edge_ac_xy_q[W-1:0];
    ac_v[2] = edge_ac_z_q[W-1:0];
  end

  rti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .ray_i   (ray_i),
    .a_i     (a_v),
    .ab_i    (ab_v),
    .ac_i    (ac_v),
    .thr_i   (det_thr_q),
    .valid_o (f_valid),
    .cls_o   (f_cls),
    .detm_o  (f_detm),
    .tnm_o   (f_tnm)
  );

  rti_queue #(.DATA_W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  ({f_cls, f_detm, f_tnm}),
    .valid_o (q_valid),
    .data_o  (q_data),
    .full_o  (q_full)
  );

  assign {q_cls, q_detm, q_tnm} = q_data;

  rti_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .cls_i      (q_cls),
    .detm_i     (q_detm),
    .tnm_i      (q_tnm),
    .min_dist_i (min_dist_q),
    .valid_o    (valid_o),
    .res_o      (res_o)
  );

  // queue never receives a word while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(f_valid && q_full))
    else $error("queue overflow");

  // every accepted ray yields its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY valid_o)
    else $error("result missing after fixed latency");

  // an accepted hit lies at or above the minimum distance
  a_hit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.hit) |-> (res_o.distance >= min_dist_q))
    else $error("hit below minimum distance");

endmodule

`default_nettype wire

>>> test/rti_checker.sv
// Scoreboard for the ray/triangle intersection block: mirrors the triangle
// registers, predicts one result word per accepted ray and compares it.
// Depends on rti_pkg for the ray, result, reason and register index types.
`timescale 1ns / 100ps

module rti_checker import rti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  ray_t        ray_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        valid_i,
  input  res_t        res_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          hits_o
);

  // mirrored triangle registers
  logic [63:0] vtx_xy, ab_xy, ac_xy;
  logic [31:0] vtx_z, ab_z, ac_z;
  logic [62:0] det_thr;
  logic [30:0] min_dist;

  res_t expected_results[$];

  typedef logic signed [127:0] wide_t;

  function automatic wide_t sx(logic [31:0] v);
    return wide_t'(signed'(v));
  endfunction

  // Exact fixed-point intersection test of one ray against the held triangle
  function automatic res_t intersect_ray(ray_t r);
    wide_t a0, a1, a2, b0, b1, b2, c0, c1, c2, d0, d1, d2, s0, s1, s2;
    wide_t p0, p1, p2, q0, q1, q2, det, un, vn, tn, t;
    logic [127:0] tmag;
    logic tneg;
    res_t res;
    res.hit = 1'b0;
    res.distance = r.best_distance;
    res.reason = RSN_SAME;
    if (r.from_this_triangle) return res;
    a0 = sx(vtx_xy[63:32]); a1 = sx(vtx_xy[31:0]); a2 = sx(vtx_z);
    b0 = sx(ab_xy[63:32]);  b1 = sx(ab_xy[31:0]);  b2 = sx(ab_z);
    c0 = sx(ac_xy[63:32]);  c1 = sx(ac_xy[31:0]);  c2 = sx(ac_z);
    d0 = sx(r.dir_x); d1 = sx(r.dir_y); d2 = sx(r.dir_z);
    s0 = sx(r.origin_x) - a0; s1 = sx(r.origin_y) - a1; s2 = sx(r.origin_z) - a2;
    // p = dir x AC, q = s x AB
    p0 = d1 * c2 - d2 * c1; p1 = d2 * c0 - d0 * c2; p2 = d0 * c1 - d1 * c0;
    q0 = s1 * b2 - s2 * b1; q1 = s2 * b0 - s0 * b2; q2 = s0 * b1 - s1 * b0;
    det = b0 * p0 + b1 * p1 + b2 * p2;
    un  = s0 * p0 + s1 * p1 + s2 * p2;
    vn  = d0 * q0 + d1 * q1 + d2 * q2;
    tn  = c0 * q0 + c1 * q1 + c2 * q2;
    // fold the back-facing orientation onto the front-facing one
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (det == 0 || det < wide_t'({65'd0, det_thr})) begin
      res.reason = RSN_PARALLEL;
      return res;
    end
    if (un < 0 || un > det) begin
      res.reason = RSN_U_OUT;
      return res;
    end
    if (vn < 0 || un + vn > det) begin
      res.reason = RSN_V_OUT;
      return res;
    end
    tneg = tn < 0;
    tmag = tneg ? -tn : tn;
    tmag = (tmag << 16) / det;
    t = tneg ? -wide_t'(tmag) : wide_t'(tmag);
    if (t < wide_t'({97'd0, min_dist}) || t >= wide_t'({97'd0, r.best_distance})) begin
      res.reason = RSN_DIST;
      return res;
    end
    res.hit = 1'b1;
    res.distance = t[30:0];
    res.reason = RSN_HIT;
    return res;
  endfunction

  // Track register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_xy <= '0; vtx_z <= '0; ab_xy <= '0; ab_z <= '0;
      ac_xy <= '0; ac_z <= '0; det_thr <= 63'd1; min_dist <= 31'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VERTEX_A_XY:  vtx_xy   <= cfg_data_i;
        CFG_VERTEX_A_Z:   vtx_z    <= cfg_data_i[31:0];
        CFG_EDGE_AB_XY:   ab_xy    <= cfg_data_i;
        CFG_EDGE_AB_Z:    ab_z     <= cfg_data_i[31:0];
        CFG_EDGE_AC_XY:   ac_xy    <= cfg_data_i;
        CFG_EDGE_AC_Z:    ac_z     <= cfg_data_i[31:0];
        CFG_DET_THRESH:   det_thr  <= cfg_data_i[62:0];
        CFG_MIN_DISTANCE: min_dist <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  initial begin
    fail_count_o = 0;
    checked_o = 0;
    hits_o = 0;
  end

  assign pending_o = expected_results.size();

  // Predict on accepted rays, compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) expected_results.push_back(intersect_ray(ray_i));
      if (valid_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: hit=%0d distance=%0h reason=%0d",
                 res_i.hit, res_i.distance, res_i.reason);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          if (want.hit) hits_o++;
          if (res_i.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, res_i.hit);
            fail_count_o++;
          end
          if (res_i.distance !== want.distance) begin
            $error("distance: expected %0h, got %0h", want.distance, res_i.distance);
            fail_count_o++;
          end
          if (res_i.reason !== want.reason) begin
            $error("reason: expected %0d, got %0d", want.reason, res_i.reason);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

>>> test/tb_ray_triangle_intersect.sv
// Testbench top for ray_triangle_intersect: clock, reset, triangle set-up and
// ray stimulus; checking is done by rti_checker. Depends on rti_pkg.
`timescale 1ns / 100ps

module tb_ray_triangle_intersect;
  import rti_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ray_t        ray_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        valid_o;
  res_t        res_o;
  int          fail_count, pending, checked, hits;

  // triangle currently programmed, used to aim rays at it
  int tri_a[3], tri_ab[3], tri_ac[3];
  int rays_sent;

  always #4 clk_i = ~clk_i;

  ray_triangle_intersect dut (
    .clk_i, .rst_ni, .start, .busy, .ray_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_o, .res_o
  );

  rti_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .ray_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_i(valid_o), .res_i(res_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .hits_o(hits)
  );

  // Hard stop
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Write one register; call at a falling edge, leaves the enable high
  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // Program a full triangle plus threshold and minimum distance
  task automatic load_triangle(int a[3], int ab[3], int ac[3], logic [63:0] thr,
                               logic [63:0] mind);
    tri_a = a; tri_ab = ab; tri_ac = ac;
    write_reg(CFG_VERTEX_A_XY, {a[0], a[1]});
    write_reg(CFG_VERTEX_A_Z, {32'd0, a[2]});
    write_reg(CFG_EDGE_AB_XY, {ab[0], ab[1]});
    write_reg(CFG_EDGE_AB_Z, {32'd0, ab[2]});
    write_reg(CFG_EDGE_AC_XY, {ac[0], ac[1]});
    write_reg(CFG_EDGE_AC_Z, {32'd0, ac[2]});
    write_reg(CFG_DET_THRESH, thr);
    write_reg(CFG_MIN_DISTANCE, mind);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one ray, hold it until accepted, then, for a nonzero gap, drop start and idle
  task automatic send_ray(ray_t r, int gap);
    logic bz;
    start <= 1'b1;
    ray_i <= r;
    forever begin
      bz = busy;
      @(posedge clk_i);
      if (!bz) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    rays_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Let every outstanding word drain, then keep idling with start low
  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (pending != 0 && n < 20000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (60) @(negedge clk_i);
  endtask

  function automatic int rnd_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r.from_this_triangle = ($urandom_range(0, 9) == 0);
    return r;
  endfunction

  // Ray aimed at a point inside (or just outside) the triangle
  function automatic ray_t aimed_ray();
    ray_t r;
    longint u, v, tgt, org, dir;
    int k;
    u = longint'($urandom_range(0, 260));
    v = longint'($urandom_range(0, 32'(260 - u)));
    k = int'($urandom_range(1, 4));
    r = '0;
    for (int i = 0; i < 3; i++) begin
      tgt = tri_a[i] + (longint'(tri_ab[i]) * u + longint'(tri_ac[i]) * v) / 256;
      org = longint'(rnd_coord(1 << 20));
      dir = (tgt - org) / k;
      case (i)
        0: begin r.origin_x = 32'(org); r.dir_x = 32'(dir); end
        1: begin r.origin_y = 32'(org); r.dir_y = 32'(dir); end
        default: begin r.origin_z = 32'(org); r.dir_z = 32'(dir); end
      endcase
    end
    r.best_distance = ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF
                      : 31'($urandom_range(0, 5 << 16));
    r.from_this_triangle = ($urandom_range(0, 19) == 0);
    return r;
  endfunction

  function automatic ray_t next_ray();
    int pick;
    ray_t r;
    pick = $urandom_range(0, 9);
    if (pick < 7) return aimed_ray();
    r = random_ray();
    if (pick == 7) begin
      r.origin_x >>>= 12; r.origin_y >>>= 12; r.origin_z >>>= 12;
      r.dir_x >>>= 12; r.dir_y >>>= 12; r.dir_z >>>= 12;
    end
    return r;
  endfunction

  initial begin
    int a[3], ab[3], ac[3];
    int gap_max;
    ray_t r;
    logic [63:0] thr, mind;
    rays_sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: degenerate reset triangle, same-triangle flag, field extremes
    r = '0;
    send_ray(r, 0);
    r.from_this_triangle = 1'b1;
    send_ray(r, 1);
    r = '1;
    send_ray(r, 0);
    r.from_this_triangle = 1'b0;
    send_ray(r, 2);
    drain();

    // Directed: unit triangle in the z=0 plane, rays along -z
    a = '{0, 0, 0}; ab = '{1 << 16, 0, 0}; ac = '{0, 1 << 16, 0};
    load_triangle(a, ab, ac, 64'd1, 64'd0);
    r = '0;
    r.origin_x = 1 << 14; r.origin_y = 1 << 14; r.origin_z = 2 << 16;
    r.dir_z = -(1 << 16); r.best_distance = 31'h7FFF_FFFF;
    send_ray(r, 0);                           // hit at t = 2.0
    r.best_distance = 31'(2 << 16); send_ray(r, 0); // t equal to best: rejected
    r.best_distance = 31'h7FFF_FFFF;
    r.dir_z = 1 << 16; send_ray(r, 0);        // behind the origin
    r.dir_z = -(1 << 16);
    r.origin_x = -1; send_ray(r, 0);          // just left of u = 0
    r.origin_x = 0; r.origin_y = 0; send_ray(r, 0);  // corner A, inside
    r.origin_x = 1 << 16; send_ray(r, 0);     // corner B, u = 1
    r.origin_x = 0; r.origin_y = 1 << 16; send_ray(r, 0); // corner C
    r.origin_y = -5; send_ray(r, 0);          // v below zero
    r.origin_x = 1 << 15; r.origin_y = (1 << 15) + 1; send_ray(r, 0); // u + v > 1
    r.dir_z = 0; r.dir_x = 1 << 16; send_ray(r, 0);   // parallel to plane
    r = '0; r.origin_z = 1 << 16; r.dir_z = 32'sh8000_0000;
    r.best_distance = 31'h7FFF_FFFF; send_ray(r, 0); // most negative direction
    r.dir_z = -1; send_ray(r, 0);             // very long t
    drain();

    // Threshold extremes and minimum distance extremes
    load_triangle(a, ab, ac, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF);
    r = '0; r.origin_z = 1 << 16; r.dir_z = -(1 << 16); r.best_distance = 31'h7FFF_FFFF;
    send_ray(r, 0);
    drain();
    load_triangle(a, ab, ac, 64'd0, 64'h7FFF_FFFF);
    send_ray(r, 0);
    r.dir_x = 1 << 16; r.dir_z = 0; send_ray(r, 0); // zero det with zero threshold
    drain();

    // All-ones vertex, threshold and minimum distance, extreme edges and random rays
    a = '{-1, -1, -1}; ab = '{32'h7FFF_FFFF, 32'h8000_0000, -1};
    ac = '{32'h8000_0000, 32'h7FFF_FFFF, 1};
    load_triangle(a, ab, ac, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 8; i++) send_ray(random_ray(), 0);
    drain();

    // Random phases over several triangles and settings
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 3; i++) begin
        a[i]  = rnd_coord(1 << 19);
        ab[i] = rnd_coord(1 << 18);
        ac[i] = rnd_coord(1 << 18);
      end
      case (ph % 4)
        0: thr = 64'd0;
        1: thr = 64'd1;
        2: thr = {$urandom, $urandom} >> ($urandom_range(20, 63));
        default: thr = {1'b0, 63'h7FFF_FFFF_FFFF_FFFF} >> ($urandom_range(0, 40) + 24);
      endcase
      case (ph % 3)
        0: mind = 64'd0;
        1: mind = 64'($urandom_range(0, 1 << 16));
        default: mind = 64'd1;
      endcase
      load_triangle(a, ab, ac, thr, mind);
      gap_max = (ph == 2) ? 0 : 12;
      for (int n = 0; n < 170; n++) begin
        send_ray(next_ray(), (n % 50 < 10) ? 0 : $urandom_range(0, gap_max));
      end
      drain();
    end

    drain();
    $display("Sent %0d rays across 11 triangle settings; %0d results checked, %0d hits.",
             rays_sent, checked, hits);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rti_pkg.sv
src/rti_front.sv
src/rti_queue.sv
src/rti_back.sv
src/ray_triangle_intersect.sv
test/rti_checker.sv
test/tb_ray_triangle_intersect.sv
